// ===== design/json_token_classifier_unit_assert.svh =====
// Assertion macros shared by the json token classifier RTL.
`ifndef JSON_TOKEN_CLASSIFIER_UNIT_ASSERT_SVH
`define JSON_TOKEN_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define JTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/jtc_pkg.sv =====
// Shared types, character codes and helper functions of the json token classifier.
`default_nettype none

package jtc_pkg;

    typedef enum logic [3:0] {
        TK_INVALID  = 4'd0,
        TK_NULL     = 4'd1,
        TK_TRUE     = 4'd2,
        TK_FALSE    = 4'd3,
        TK_LBRACE   = 4'd4,
        TK_RBRACE   = 4'd5,
        TK_LBRACKET = 4'd6,
        TK_RBRACKET = 4'd7,
        TK_COMMA    = 4'd8,
        TK_NUMBER   = 4'd9,
        TK_STRING   = 4'd10
    } token_kind_t;

    typedef enum logic [3:0] {
        NS_START   = 4'd0,
        NS_MINUS   = 4'd1,
        NS_INT     = 4'd2,
        NS_FRAC    = 4'd3,
        NS_EXP     = 4'd4,
        NS_EXPSIGN = 4'd5,
        NS_EXPDIG  = 4'd6,
        NS_DEAD    = 4'd7
    } num_state_t;

    // Per-term tracking: characters seen (saturating), live keywords, number check.
    typedef struct packed {
        logic [2:0] pos;
        logic [2:0] alive;
        num_state_t num;
    } term_state_t;

    localparam term_state_t TERM_BEGIN = '{pos: 3'd0, alive: 3'b111, num: NS_START};

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_EXP      = 8'h65;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? (c + 8'h20) : c;
    endfunction

    function automatic logic [7:0] kw_null_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = 8'h6E;
            2'd1:    r = 8'h75;
            default: r = 8'h6C;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_true_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = 8'h74;
            2'd1:    r = 8'h72;
            2'd2:    r = 8'h75;
            default: r = 8'h65;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_false_char(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'h66;
            3'd1:    r = 8'h61;
            3'd2:    r = 8'h6C;
            3'd3:    r = 8'h73;
            3'd4:    r = 8'h65;
            default: r = 8'h66;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/jtc_term_check.sv =====
// Term tracker: keyword match, number recognizer step and final classification.
`default_nettype none

module jtc_term_check (
    input  wire logic [7:0]           ch,
    input  wire jtc_pkg::term_state_t term_in,
    output jtc_pkg::term_state_t      term_out,
    output jtc_pkg::token_kind_t      kind
);
    import jtc_pkg::*;

    logic [7:0] lc;
    logic       dg;

    assign lc = to_lower(ch);
    assign dg = is_digit(ch);

    // Advance the term by one character.
    always_comb
    begin
        term_out = term_in;
        if (!((term_in.pos < 3'd4) && (lc == kw_null_char(term_in.pos[1:0]))))
            term_out.alive[0] = 1'b0;
        if (!((term_in.pos < 3'd4) && (lc == kw_true_char(term_in.pos[1:0]))))
            term_out.alive[1] = 1'b0;
        if (!((term_in.pos < 3'd5) && (lc == kw_false_char(term_in.pos))))
            term_out.alive[2] = 1'b0;
        if (term_in.pos < 3'd7)
            term_out.pos = term_in.pos + 3'd1;

        case (term_in.num)
            NS_START:
                term_out.num = (ch == CH_MINUS) ? NS_MINUS : (dg ? NS_INT : NS_DEAD);
            NS_MINUS:
                term_out.num = dg ? NS_INT : NS_DEAD;
            NS_INT:
                term_out.num = dg ? NS_INT : (ch == CH_DOT) ? NS_FRAC :
                               (lc == CH_EXP) ? NS_EXP : NS_DEAD;
            NS_FRAC:
                term_out.num = dg ? NS_FRAC : (lc == CH_EXP) ? NS_EXP : NS_DEAD;
            NS_EXP:
                term_out.num = dg ? NS_EXPDIG :
                               ((ch == CH_PLUS) || (ch == CH_MINUS)) ? NS_EXPSIGN : NS_DEAD;
            NS_EXPSIGN, NS_EXPDIG:
                term_out.num = dg ? NS_EXPDIG : NS_DEAD;
            default:
                term_out.num = NS_DEAD;
        endcase
    end

    // Classify the term as it stands; keywords win over the number check.
    always_comb
    begin
        if (term_in.alive[0] && (term_in.pos == 3'd4))
            kind = TK_NULL;
        else if (term_in.alive[2] && (term_in.pos == 3'd5))
            kind = TK_FALSE;
        else if (term_in.alive[1] && (term_in.pos == 3'd4))
            kind = TK_TRUE;
        else if ((term_in.num == NS_INT) || (term_in.num == NS_FRAC) ||
                 (term_in.num == NS_EXPDIG))
            kind = TK_NUMBER;
        else
            kind = TK_INVALID;
    end

endmodule

`default_nettype wire

// ===== design/jtc_scanner.sv =====
// Scanner: phase state machine and term state, one character per step.
`default_nettype none

module jtc_scanner (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           ch,
    input  wire logic                 end_marker,
    output logic                      emit,
    output jtc_pkg::token_kind_t      kind
);
    import jtc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_STRING = 2'd1,
        PH_TERM   = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    term_state_t term_reg, term_next;
    term_state_t feed_in, feed_out;
    token_kind_t term_kind;

    // Idle starts a fresh term; inside a term keep feeding the running one.
    assign feed_in = (phase_reg == PH_TERM) ? term_reg : TERM_BEGIN;

    jtc_term_check u_term (
        .ch       (ch),
        .term_in  (feed_in),
        .term_out (feed_out),
        .kind     (term_kind)
    );

    always_comb
    begin
        phase_next = phase_reg;
        term_next  = term_reg;
        emit       = 1'b0;
        kind       = TK_INVALID;
        case (phase_reg)
            PH_STRING:
            begin
                if (end_marker)
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                end
                else if (ch == CH_QUOTE)
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    kind       = TK_STRING;
                end
            end
            PH_TERM:
            begin
                if (end_marker || is_ws(ch))
                begin
                    phase_next = PH_IDLE;
                    term_next  = TERM_BEGIN;
                    emit       = 1'b1;
                    kind       = term_kind;
                end
                else
                    term_next = feed_out;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (end_marker)
                    emit = 1'b1;
                else if (!is_ws(ch))
                begin
                    case (ch)
                        CH_LBRACE:   begin emit = 1'b1; kind = TK_LBRACE;   end
                        CH_RBRACE:   begin emit = 1'b1; kind = TK_RBRACE;   end
                        CH_LBRACKET: begin emit = 1'b1; kind = TK_LBRACKET; end
                        CH_RBRACKET: begin emit = 1'b1; kind = TK_RBRACKET; end
                        CH_COMMA:    begin emit = 1'b1; kind = TK_COMMA;    end
                        CH_QUOTE:    phase_next = PH_STRING;
                        default:
                        begin
                            phase_next = PH_TERM;
                            term_next  = feed_out;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            term_reg  <= TERM_BEGIN;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            term_reg  <= term_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/json_token_classifier_unit.sv =====
// Top level of the json token classifier: input register, scanner, result register.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one character per item in
//    char_code; end_marker = 1 marks end of stream and the character is ignored.
//  - Output channel (out_valid / out_stall) carries one token_kind per result:
//    0 invalid, 1 null, 2 true, 3 false, 4 '{', 5 '}', 6 '[', 7 ']',
//    8 comma, 9 number, 10 string. An item yields zero or one result.
//  - Path: an accepted item is held in the input register, scanned
//    combinationally from it, and its result is written to the result
//    register, which drives out_valid until the result is taken.
//  - Throughput: one item per cycle, set by the single scanner step between
//    the input register and the result register, except while in_stall is high.
//  - Stall: while a result waits under out_stall, an input item is still
//    taken into the input register; in_stall rises only when that register
//    holds an item that has a result to deliver and the result slot is busy.
//    Items that give no result (whitespace, string body, term characters)
//    pass through even while the output stalls.
//  - Reset (rst_n low, asynchronous): both registers empty, scanner idle
//    skipping whitespace with a fresh term.
`default_nettype none

module json_token_classifier_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       end_marker,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      token_kind
);
    import jtc_pkg::*;

    `include "json_token_classifier_unit_assert.svh"

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  char_reg;
    logic        end_reg;
    logic        out_valid_reg, out_valid_next;
    token_kind_t kind_reg;

    logic        emit;
    token_kind_t kind;
    logic        out_free;
    logic        s1_go;
    logic        in_take;

    jtc_scanner u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_go),
        .ch         (char_reg),
        .end_marker (end_reg),
        .emit       (emit),
        .kind       (kind)
    );

    // Result slot frees when empty or when its result is taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    // Advance the held item unless it has a result and nowhere to put it.
    assign s1_go    = in_valid_reg && (!emit || out_free);
    assign in_stall = in_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (s1_go)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_go && emit)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: load the character on handshake and the kind when a result is emitted, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_code;
            end_reg  <= end_marker;
        end
        if (s1_go && emit)
            kind_reg <= kind;
    end

    assign out_valid  = out_valid_reg;
    assign token_kind = kind_reg;

    `JTC_ASSERT_NOW(a_no_overwrite, out_valid_reg && out_stall, !(s1_go && emit),
        "result register overwritten while stalled")
    `JTC_ASSERT_NOW(a_end_emits, s1_go && end_reg, emit,
        "end of stream passed without a token")
    `JTC_ASSERT_NOW(a_kind_range, out_valid_reg, kind_reg <= TK_STRING,
        "token kind out of range")
    `JTC_ASSERT_NEXT(a_emit_lands, s1_go && emit, out_valid_reg,
        "emitted token did not reach the result register")

endmodule

`default_nettype wire

// ===== tb/jtc_token_checker.sv =====
// Token checker: scores every token kind leaving the classifier against a local scanner.
`timescale 1ns / 100ps

module jtc_token_checker
    import jtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       end_marker,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [3:0] token_kind,
    input  logic       wrap_up,
    output int         fail_count,
    output int         pending,
    output int         checked
);

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_STRING = 2'd1,
        SCAN_TERM   = 2'd2
    } scan_phase_t;

    localparam logic [31:0] WORD_NULL  = "null";
    localparam logic [31:0] WORD_TRUE  = "true";
    localparam logic [39:0] WORD_FALSE = "false";

    scan_phase_t  scan_q;
    term_state_t  term_q;
    scan_phase_t  next_phase;
    term_state_t  next_term;
    token_kind_t  new_kind;
    token_kind_t  want_kind;
    token_kind_t  expected_kinds[$];
    int           mismatch_count;

    assign fail_count = mismatch_count + (wrap_up ? pending : 0);

    function automatic bit blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit numeral(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // Advance keyword matching and the number recognizer by one term character.
    function automatic term_state_t fed_term(input term_state_t t, input logic [7:0] c);
        term_state_t r;
        logic [7:0]  lc;
        logic        dg;
        int          p;
        r  = t;
        lc = fold_case(c);
        dg = numeral(c);
        p  = t.pos;
        if (!(p < 4 && lc == WORD_NULL[8 * (3 - (p & 3)) +: 8]))
            r.alive[0] = 1'b0;
        if (!(p < 4 && lc == WORD_TRUE[8 * (3 - (p & 3)) +: 8]))
            r.alive[1] = 1'b0;
        if (!(p < 5 && lc == WORD_FALSE[8 * (4 - (p < 5 ? p : 0)) +: 8]))
            r.alive[2] = 1'b0;
        if (t.pos != 3'd7)
            r.pos = t.pos + 3'd1;
        case (t.num)
            NS_START:   r.num = (c == CH_MINUS) ? NS_MINUS : (dg ? NS_INT : NS_DEAD);
            NS_MINUS:   r.num = dg ? NS_INT : NS_DEAD;
            NS_INT:     r.num = dg ? NS_INT : (c == CH_DOT) ? NS_FRAC
                                : (lc == CH_EXP) ? NS_EXP : NS_DEAD;
            NS_FRAC:    r.num = dg ? NS_FRAC : (lc == CH_EXP) ? NS_EXP : NS_DEAD;
            NS_EXP:     r.num = dg ? NS_EXPDIG
                                : (c == CH_PLUS || c == CH_MINUS) ? NS_EXPSIGN : NS_DEAD;
            NS_EXPSIGN,
            NS_EXPDIG:  r.num = dg ? NS_EXPDIG : NS_DEAD;
            default:    r.num = NS_DEAD;
        endcase
        return r;
    endfunction

    // One scanner step; returns 1 when the character produces a token.
    function automatic bit scan_char(input scan_phase_t ph, input term_state_t t,
                                     input logic [7:0] c, input logic stop,
                                     output scan_phase_t ph_n, output term_state_t t_n,
                                     output token_kind_t kind);
        bit emits;
        emits = 1'b0;
        kind  = TK_INVALID;
        ph_n  = ph;
        t_n   = t;
        case (ph)
            SCAN_STRING:
            begin
                if (stop || c == CH_QUOTE)
                begin
                    ph_n  = SCAN_IDLE;
                    kind  = stop ? TK_INVALID : TK_STRING;
                    emits = 1'b1;
                end
            end
            SCAN_TERM:
            begin
                if (stop || blank(c))
                begin
                    if (t.alive[0] && t.pos == 3'd4)
                        kind = TK_NULL;
                    else if (t.alive[2] && t.pos == 3'd5)
                        kind = TK_FALSE;
                    else if (t.alive[1] && t.pos == 3'd4)
                        kind = TK_TRUE;
                    else if (t.num == NS_INT || t.num == NS_FRAC || t.num == NS_EXPDIG)
                        kind = TK_NUMBER;
                    ph_n  = SCAN_IDLE;
                    t_n   = TERM_BEGIN;
                    emits = 1'b1;
                end
                else
                    t_n = fed_term(t, c);
            end
            default:
            begin
                ph_n = SCAN_IDLE;
                if (stop)
                    emits = 1'b1;
                else if (!blank(c))
                begin
                    emits = 1'b1;
                    case (c)
                        CH_LBRACE:   kind = TK_LBRACE;
                        CH_RBRACE:   kind = TK_RBRACE;
                        CH_LBRACKET: kind = TK_LBRACKET;
                        CH_RBRACKET: kind = TK_RBRACKET;
                        CH_COMMA:    kind = TK_COMMA;
                        CH_QUOTE:
                        begin
                            emits = 1'b0;
                            ph_n  = SCAN_STRING;
                        end
                        default:
                        begin
                            emits = 1'b0;
                            ph_n  = SCAN_TERM;
                            t_n   = fed_term(TERM_BEGIN, c);
                        end
                    endcase
                end
            end
        endcase
        return emits;
    endfunction

    function automatic void flag_error(input string msg);
        if (mismatch_count < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endfunction

    initial
    begin
        mismatch_count = 0;
        pending        = 0;
        checked        = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_q = SCAN_IDLE;
            term_q = TERM_BEGIN;
            expected_kinds.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_kinds.size() == 0)
                    flag_error($sformatf("token_kind %0d with none expected", token_kind));
                else
                begin
                    want_kind = expected_kinds.pop_front();
                    if (token_kind !== want_kind)
                        flag_error($sformatf("token_kind expected %0d (%s), got %0d",
                                             want_kind, want_kind.name(), token_kind));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (scan_char(scan_q, term_q, char_code, end_marker,
                              next_phase, next_term, new_kind))
                    expected_kinds.push_back(new_kind);
                scan_q = next_phase;
                term_q = next_term;
            end
        end
        pending = expected_kinds.size();
    end

    always @(posedge wrap_up)
    begin
        if (pending != 0)
            $display("[%0t] %0d expected tokens never arrived", $realtime, pending);
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: character stimulus, handshake pressure and verdict for the token classifier.
`timescale 1ns / 100ps

module tb_top;
    import jtc_pkg::*;

    // Stimulus plan: ~500 characters spread over four handshake phases.
    localparam int ITEM_TARGET = 500;
    localparam int PHASES      = 4;
    localparam int QUIET_LIMIT = 2000;   // cycles without any handshake
    localparam int TAIL_CYCLES = 8;      // settle time after the drain

    // Per-phase pressure: none, sender gaps, receiver stalls, both.
    localparam int IDLE_PCT  [PHASES] = '{0, 69, 0, 24};
    localparam int STALL_PCT [PHASES] = '{0, 0, 69, 24};

    // Character pools, packed so that any tool can index them.
    localparam logic [39:0] DELIMS = {CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COMMA};
    localparam logic [47:0] BLANKS = {8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

    // One input item: a character or an end of stream.
    typedef struct packed {
        logic       stop;
        logic [7:0] ch;
    } char_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'h00;
    logic       end_marker = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] token_kind;
    logic       wrap_up = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int chars_sent = 0;
    int ends_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet = 0;

    char_item_t burst[$];

    always #1 clk = ~clk;

    json_token_classifier_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .end_marker (end_marker),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind)
    );

    jtc_token_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .end_marker (end_marker),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .wrap_up    (wrap_up),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Receiver: stall at random with the phase's rate; change only at the falling edge.
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item: insert random sender gaps, then hold it until the
    // classifier takes it at a rising edge.
    task automatic send_item(input char_item_t it);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        char_code  = it.ch;
        end_marker = it.stop;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
        if (it.stop)
            ends_sent++;
    endtask

    task automatic flush_burst();
        foreach (burst[i])
            send_item(burst[i]);
        burst.delete();
    endtask

    task automatic push_ch(input logic [7:0] c);
        burst.push_back('{stop: 1'b0, ch: c});
    endtask

    // End of stream carries a random, ignored character.
    task automatic push_end();
        burst.push_back('{stop: 1'b1, ch: 8'($urandom_range(0, 255))});
    endtask

    function automatic logic [7:0] pick_blank();
        return BLANKS[8 * $urandom_range(0, 5) +: 8];
    endfunction

    // Queue a literal word; with mixed set, flip letter case at random.
    task automatic push_word(input string w, input bit mixed);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++)
        begin
            c = w[i];
            if (mixed && $urandom_range(0, 1))
                c = c ^ 8'h20;
            push_ch(c);
        end
    endtask

    // Close a term: mostly whitespace, sometimes the end of the stream.
    task automatic close_term();
        if ($urandom_range(0, 7) == 0)
            push_end();
        else
            push_ch(pick_blank());
    endtask

    task automatic push_digits(input int n);
        repeat (n)
            push_ch(8'h30 + 8'($urandom_range(0, 9)));
    endtask

    // Queue one random token. Most are well formed with random content;
    // the rest are near misses, raw byte noise and stray ends of stream.
    task automatic build_token();
        string      w;
        logic [7:0] c;
        bit         broken;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                push_ch(DELIMS[8 * $urandom_range(0, 4) +: 8]);
                if ($urandom_range(0, 1))
                    push_ch(pick_blank());
            end
            2:
            begin
                // String body may hold any byte but the quote, whitespace included.
                push_ch(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    c = 8'($urandom_range(0, 255));
                    push_ch(c == CH_QUOTE ? 8'h78 : c);
                end
                if ($urandom_range(0, 7) == 0)
                    push_end();
                else
                    push_ch(CH_QUOTE);
            end
            3, 4:
            begin
                case ($urandom_range(0, 2))
                    0:       w = "null";
                    1:       w = "true";
                    default: w = "false";
                endcase
                // Near misses: truncate, extend or corrupt the keyword.
                case ($urandom_range(0, 5))
                    0:       w = w.substr(0, w.len() - 2);
                    1:       w = {w, "l"};
                    2:       w[1] = 8'h71;
                    default: ;
                endcase
                push_word(w, 1'b1);
                close_term();
            end
            5, 6:
            begin
                // Number: sign, digits, fraction, exponent; broken ones miss
                // required digits.
                broken = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 1))
                    push_ch(CH_MINUS);
                push_digits(broken && $urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
                if ($urandom_range(0, 1))
                begin
                    push_ch(CH_DOT);
                    push_digits($urandom_range(0, 2));
                end
                if ($urandom_range(0, 1) || broken)
                begin
                    push_ch($urandom_range(0, 1) ? CH_EXP : 8'h45);
                    case ($urandom_range(0, 2))
                        0:       push_ch(CH_PLUS);
                        1:       push_ch(CH_MINUS);
                        default: ;
                    endcase
                    push_digits(broken ? 0 : $urandom_range(1, 2));
                end
                close_term();
            end
            7:
            begin
                // Raw bytes: any value, so every char_code bit toggles.
                repeat ($urandom_range(1, 4))
                    push_ch(8'($urandom_range(0, 255)));
                close_term();
            end
            8:
                push_end();
            default:
                repeat ($urandom_range(1, 3))
                    push_ch(pick_blank());
        endcase
    endtask

    initial
    begin
        int ph;

        // Hold reset, then release it away from the rising edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = IDLE_PCT[ph];
            stall_pct     = STALL_PCT[ph];
            if (ph == 0)
            begin
                // Directed: every delimiter, a string holding a NUL byte,
                // a mixed-case keyword, a full number, a brace swallowed by a
                // term with a high byte and ended by end of stream, end while
                // idle, and end inside a string holding a tab.
                push_word("{}[],", 1'b0);
                push_ch(CH_QUOTE);
                push_ch(8'h00);
                push_ch(CH_QUOTE);
                push_word("nUlL", 1'b0);
                push_ch(8'h0A);
                push_word("-1.5E+9", 1'b0);
                push_ch(8'h20);
                push_ch(8'h61);
                push_ch(CH_LBRACE);
                push_ch(8'hFF);
                push_end();
                push_end();
                push_ch(CH_QUOTE);
                push_ch(8'h09);
                push_end();
                flush_burst();
            end
            while (chars_sent < (ph + 1) * ITEM_TARGET / PHASES)
            begin
                build_token();
                flush_burst();
            end
        end

        // Drop valid, drain the outstanding tokens, then let the pipe settle.
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        wrap_up = 1'b1;
        @(negedge clk);

        $display("Sent %0d characters (%0d end-of-stream marks) through four pressure phases;",
                 chars_sent, ends_sent);
        $display("compared %0d tokens, %0d failures.", checked, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
